### src/i2a_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package i2a_pkg;

    // Input width in use; bits of the value port above this are ignored
    localparam int VALUE_WIDTH = 64;
    // Decimal digits held by the converter: enough for any magnitude up to 2^63
    localparam int MAX_DIGITS  = 19;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_NINE  = 6'd57;

    typedef logic [VALUE_WIDTH-1:0] mag_t;

    // Commands from the sequencer to the BCD converter
    typedef struct packed {
        logic start;
        mag_t mag;
        logic shift_digit;
    } i2a_ctrl_t;

    // Status from the BCD converter
    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } i2a_stat_t;

endpackage

### src/i2a_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), with a digit shift-out.
module i2a_dabble (
    input  logic              clk,
    input  logic              rst_n,
    input  i2a_pkg::i2a_ctrl_t ctrl,
    output i2a_pkg::i2a_stat_t stat
);
    import i2a_pkg::*;

    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_next;
    mag_t                   mag_reg;
    logic [BIT_CNT_W-1:0]   cnt_reg;
    logic [BIT_CNT_W-1:0]   cnt_next;

    // Add 3 to every digit of 5 or more before the next doubling
    always_comb
    begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb
    begin
        bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
        cnt_next = cnt_reg - BIT_CNT_W'(1);
    end

    // Bit counter: control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.start)
        begin
            cnt_reg <= BIT_CNT_W'(VALUE_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Magnitude and BCD shift registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mag_reg <= ctrl.mag;
            bcd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            mag_reg <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
        else if (ctrl.shift_digit)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    assign stat.busy      = (cnt_reg != '0);
    assign stat.top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

### src/signed_int64_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per result.
//
// Input channel: value with in_valid / in_ready. One request is one signed
// two's-complement integer. Output channel: char_code and last with
// out_valid / out_ready; a request gives a run of 1 to 20 characters, most
// significant first, '-' leading for negatives, last set on the final one.
// Operation: after acceptance the magnitude goes bit-serially through a
// shift-and-add-3 converter, one input bit per cycle, and the sequencer
// then sees it finish. A negative value then loads '-' into the output
// register, and the 19 BCD digits are walked one per cycle while the
// receiver keeps up, leading zeros dropped without output. One request is
// converted at a time; in_ready rises as soon as the final character sits
// in the output register. If the receiver stalls, the output register holds
// its character and the digit walk waits before loading the next one.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns to idle; no state carries between requests.
module signed_int64_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  char_code,
    output logic        last
);
    import i2a_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 sign_reg;
    logic                 sign_next;
    logic                 started_reg;
    logic                 started_next;
    logic [DIG_CNT_W-1:0] left_reg;
    logic [DIG_CNT_W-1:0] left_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [5:0]           char_reg;
    logic [5:0]           char_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 in_acc;
    logic                 can_load;
    logic                 in_sign;
    mag_t                 raw;
    i2a_ctrl_t            ctrl;
    i2a_stat_t            stat;

    // Bit-serial BCD converter
    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;
    assign raw      = value[VALUE_WIDTH-1:0];
    assign in_sign  = raw[VALUE_WIDTH-1];

    // Sequencer: convert, then sign, then walk the digits
    always_comb
    begin
        state_next       = state_reg;
        sign_next        = sign_reg;
        started_next     = started_reg;
        left_next        = left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        char_next        = char_reg;
        last_next        = last_reg;
        ctrl.start       = 1'b0;
        ctrl.mag         = in_sign ? (~raw + mag_t'(1)) : raw;
        ctrl.shift_digit = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ctrl.start   = 1'b1;
                    sign_next    = in_sign;
                    started_next = 1'b0;
                    left_next    = DIG_CNT_W'(MAX_DIGITS);
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!stat.busy)
                begin
                    state_next = sign_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Leading zero: drop it, but always keep the units digit
                if (!started_reg && stat.top_digit == 4'd0 && left_reg != DIG_CNT_W'(1))
                begin
                    ctrl.shift_digit = 1'b1;
                    left_next        = left_reg - DIG_CNT_W'(1);
                end
                else if (can_load)
                begin
                    ctrl.shift_digit = 1'b1;
                    started_next     = 1'b1;
                    left_next        = left_reg - DIG_CNT_W'(1);
                    out_valid_next   = 1'b1;
                    char_next        = CH_ZERO + {2'b00, stat.top_digit};
                    last_next        = (left_reg == DIG_CNT_W'(1));
                    if (left_reg == DIG_CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            left_reg      <= '0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            left_reg      <= left_next;
            sign_reg      <= sign_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    // A run never ends on the minus sign
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> char_reg != CH_MINUS)
        else $error("run ends on a minus sign");

    // Characters are only '-' or decimal digits
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == CH_MINUS) ||
                          (char_reg >= CH_ZERO && char_reg <= CH_NINE))
        else $error("character code out of range");

    // An accepted request starts the converter
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_CONV && stat.busy)
        else $error("converter not started on request");

    // The converter is quiet whenever the block is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !stat.busy)
        else $error("converter busy while idle");

    // The digit counter never runs out before the final character
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> left_reg != '0)
        else $error("digit counter exhausted during emission");

endmodule

### verif/tb_signed_int64_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb_signed_int64_to_decimal_ascii;
    import i2a_pkg::*;

    localparam int RANDOM_REQUESTS = 250;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 100;

    // One character of the expected text
    typedef struct packed {
        logic [5:0] code;
        logic       is_last;
    } glyph_t;

    // Holds the text each accepted request should produce, in order
    class decimal_text_board;
        glyph_t pending_glyphs[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // Decimal spelling of the low VALUE_WIDTH bits read as two's complement
        function automatic void note_request(logic [63:0] v);
            logic [63:0] mask;
            logic [63:0] raw;
            logic [63:0] ext;
            logic [63:0] mag;
            logic        neg;
            logic [5:0]  digits[$];
            glyph_t      g;
            mask = (VALUE_WIDTH == 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
            raw  = v & mask;
            neg  = raw[VALUE_WIDTH-1];
            ext  = neg ? (raw | ~mask) : raw;
            mag  = neg ? (~ext + 64'd1) : ext;
            // zero spells as a single digit
            if (mag == 64'd0)
            begin
                g.code    = CH_ZERO;
                g.is_last = 1'b1;
                pending_glyphs.push_back(g);
                return;
            end
            while (mag != 64'd0)
            begin
                digits.push_front(CH_ZERO + 6'(mag % 64'd10));
                mag = mag / 64'd10;
            end
            if (neg)
            begin
                g.code    = CH_MINUS;
                g.is_last = 1'b0;
                pending_glyphs.push_back(g);
            end
            for (int i = 0; i < digits.size(); i++)
            begin
                g.code    = digits[i];
                g.is_last = (i == digits.size() - 1);
                pending_glyphs.push_back(g);
            end
        endfunction

        // Compare one accepted character with the oldest expectation
        function automatic void check_glyph(logic [5:0] code, logic is_last);
            glyph_t exp_g;
            if (pending_glyphs.size() == 0)
            begin
                $error("unexpected character: char_code %0d last %0d", code, is_last);
                errors++;
                return;
            end
            exp_g = pending_glyphs.pop_front();
            if (code !== exp_g.code)
            begin
                $error("char_code: expected %0d, got %0d", exp_g.code, code);
                errors++;
            end
            if (is_last !== exp_g.is_last)
            begin
                $error("last: expected %0d, got %0d", exp_g.is_last, is_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_glyphs.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  char_code;
    logic        last;

    decimal_text_board board;
    bit                steady;
    int                cycles;

    signed_int64_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(logic [63:0] v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(v);
    endtask

    function automatic logic [63:0] pow10(int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) p = p * 64'd10;
        return p;
    endfunction

    // Random value, weighted towards chosen digit counts and boundaries
    function automatic logic [63:0] pick_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mag;
        int          k;
        case ($urandom_range(0, 3))
            0: mag = {$urandom, $urandom};
            1:
            begin
                k   = $urandom_range(1, 19);
                lo  = pow10(k - 1);
                hi  = (k == 19) ? 64'h7FFF_FFFF_FFFF_FFFF : pow10(k) - 64'd1;
                mag = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
                if ($urandom_range(0, 1)) mag = ~mag + 64'd1;
            end
            2:
            begin
                mag = 64'($urandom_range(0, 1000));
                if ($urandom_range(0, 1)) mag = ~mag + 64'd1;
            end
            default:
            begin
                // powers of ten and the extremes, nudged a little
                if ($urandom_range(0, 1))
                    mag = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
                else
                    mag = 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) mag = ~mag + 64'd1;
            end
        endcase
        return mag;
    endfunction

    // Result side: random stall before each character, then take it
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_glyph(char_code, last);
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] directed[$];
        board    = new();
        steady   = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, single digits, carries across powers of ten, extremes
        directed = '{
            64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99,
            64'd100, 64'd12345, -64'sd12345,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'd999999999999999999, 64'd1000000000000000000,
            -64'sd1000000000000000000, -64'sd999999999999999999,
            64'd4294967296, -64'sd2147483648,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
        };
        foreach (directed[i]) send_request(directed[i]);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // alternate stretches of back-to-back traffic with random idling
            if (n % 60 == 0) steady = (n % 120 == 60);
            // let the converter drain completely once
            if (n == 130)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.outstanding() != 0) @(posedge clk);
            end
            send_request(pick_value());
        end
        in_valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
